FILE: hw/rtl/tclp_pkg.sv
// Shared types and constants of the tuning command line parser.
package tclp_pkg;

  // Width of all stored and parsed values (signed hundredths)
  localparam int unsigned ValW = 23;
  localparam int unsigned LineMaxDefault = 200;

  // Characters of the line syntax
  localparam logic [7:0] CharEquals = 8'h3D;
  localparam logic [7:0] CharEnd    = 8'h21;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharP      = 8'h50;
  localparam logic [7:0] CharI      = 8'h49;
  localparam logic [7:0] CharD      = 8'h44;
  localparam logic [7:0] CharT      = 8'h54;
  localparam logic [8:0] DigitBase  = 9'd48;

  // Positional digit weights
  localparam logic signed [ValW-1:0] Wt10    = ValW'(10);
  localparam logic signed [ValW-1:0] Wt100   = ValW'(100);
  localparam logic signed [ValW-1:0] Wt1000  = ValW'(1000);
  localparam logic signed [ValW-1:0] Wt10000 = ValW'(10000);

  // Field length: counts field bytes, saturates at FieldLenMax
  localparam logic [2:0] FieldLenMax = 3'd7;
  localparam logic [2:0] FieldLen4   = 3'd4;
  localparam logic [2:0] FieldLen5   = 3'd5;
  localparam logic [2:0] FieldLen6   = 3'd6;

  // Value selected by the command letter
  typedef enum logic [2:0] {
    SEL_P    = 3'd0,
    SEL_I    = 3'd1,
    SEL_D    = 3'd2,
    SEL_T    = 3'd3,
    SEL_NONE = 3'd4
  } sel_e;

  // Finished line, handed from the line tracker to the value unit
  typedef struct packed {
    sel_e            sel;
    logic            overflow;
    logic            negative;
    logic [2:0]      field_len;
    logic [5:0][7:0] window;     // [0] is the most recent field byte
  } line_rec_t;

  function automatic sel_e decode_letter(input logic [7:0] letter);
    sel_e s;
    unique case (letter)
      CharP:   s = SEL_P;
      CharI:   s = SEL_I;
      CharD:   s = SEL_D;
      CharT:   s = SEL_T;
      default: s = SEL_NONE;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/tclp_if.sv
// Handshake channels of the tuning command line parser: byte input and result output.
interface tclp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tclp_result_if;
  logic              valid;
  logic              ready;
  logic [2:0]        param_select;
  logic signed [22:0] parsed_value;
  logic              line_overflow;
  logic signed [22:0] p_gain_value;
  logic signed [22:0] i_gain_value;
  logic signed [22:0] d_gain_value;
  logic signed [22:0] target_value;

  modport source (
    output valid, output param_select, output parsed_value, output line_overflow,
    output p_gain_value, output i_gain_value, output d_gain_value, output target_value,
    input ready
  );
  modport sink (
    input valid, input param_select, input parsed_value, input line_overflow,
    input p_gain_value, input i_gain_value, input d_gain_value, input target_value,
    output ready
  );
endinterface

FILE: hw/rtl/tclp_line_tracker.sv
// Line tracker: follows the bytes of one command line and registers each finished line.
module tclp_line_tracker #(
  parameter int unsigned LINE_MAX = tclp_pkg::LineMaxDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tclp_byte_if.sink           rx_i,
  output logic                rec_valid_o,
  output tclp_pkg::line_rec_t rec_o,
  input  logic                rec_ready_i
);
  import tclp_pkg::*;

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);

  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [2:0]      flen_q, flen_d;
  logic            start_q, start_d;
  logic            neg_q, neg_d;
  logic            ovf_q, ovf_d;
  logic [5:0][7:0] win_q, win_d;
  logic            rec_valid_q, rec_valid_d;
  line_rec_t       rec_q, rec_d;

  logic       accept;
  logic [7:0] b;

  assign rx_i.ready = !rec_valid_q || rec_ready_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  // Next line state and finished-line record
  always_comb begin
    len_d       = len_q;
    cmd_d       = cmd_q;
    flen_d      = flen_q;
    start_d     = start_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    win_d       = win_q;
    rec_d       = rec_q;
    rec_valid_d = rec_valid_q && !rec_ready_i;

    if (accept) begin
      // length count, command capture, overflow
      if (!ovf_q) begin
        if (len_q >= LenW'(LINE_MAX)) begin
          ovf_d = 1'b1;
        end else begin
          if (len_q == '0) begin
            cmd_d = b;
          end
          len_d = len_q + LenW'(1);
        end
      end

      if (b == CharEnd) begin
        // line done: hand it on and start a fresh line
        rec_valid_d    = 1'b1;
        rec_d.sel      = ovf_d ? SEL_NONE : decode_letter(cmd_d);
        rec_d.overflow = ovf_d;
        rec_d.negative = neg_q;
        rec_d.field_len = flen_q;
        rec_d.window   = win_q;
        len_d   = '0;
        cmd_d   = '0;
        flen_d  = '0;
        start_d = 1'b1;
        neg_d   = 1'b0;
        ovf_d   = 1'b0;
      end else if (!ovf_d) begin
        priority if (b == CharEquals) begin
          start_d = 1'b1;
          neg_d   = 1'b0;
          flen_d  = '0;
        end else if (start_q && b == CharMinus) begin
          start_d = 1'b0;
          neg_d   = 1'b1;
        end else begin
          start_d  = 1'b0;
          win_d    = {win_q[4:0], b};
          if (flen_q != FieldLenMax) begin
            flen_d = flen_q + 3'd1;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      cmd_q       <= '0;
      flen_q      <= '0;
      start_q     <= 1'b1;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      rec_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      cmd_q       <= cmd_d;
      flen_q      <= flen_d;
      start_q     <= start_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  // Payload: digit window and line record
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    rec_q <= rec_d;
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

FILE: hw/rtl/tclp_value_unit.sv
// Value unit: weighs the field digits, updates the stored values and holds the result beat.
module tclp_value_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  tclp_pkg::line_rec_t rec_i,
  output logic                rec_ready_o,
  tclp_result_if.source       res_o
);
  import tclp_pkg::*;

  logic signed [8:0]      wt [6];
  logic signed [ValW-1:0] wx [6];
  logic signed [ValW-1:0] sum;
  logic signed [ValW-1:0] value;
  logic                   len_ok;
  logic                   load;

  logic                   out_valid_q, out_valid_d;
  sel_e                   sel_q;
  logic signed [ValW-1:0] val_q;
  logic                   ovf_q;
  logic signed [ValW-1:0] gain_q [4];

  // Digit weights: byte minus the digit base, no check
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      wt[i] = signed'({1'b0, rec_i.window[i]} - DigitBase);
      wx[i] = ValW'(wt[i]);
    end
  end

  // Positional sum over the field
  always_comb begin
    len_ok = (rec_i.field_len == FieldLen4) || (rec_i.field_len == FieldLen5) ||
             (rec_i.field_len == FieldLen6);
    sum = wx[0] + wx[1] * Wt10 + wx[3] * Wt100;
    if (rec_i.field_len == FieldLen5 || rec_i.field_len == FieldLen6) begin
      sum = sum + wx[4] * Wt1000;
    end
    if (rec_i.field_len == FieldLen6) begin
      sum = sum + wx[5] * Wt10000;
    end
    if (!len_ok || rec_i.overflow) begin
      value = '0;
    end else if (rec_i.negative) begin
      value = -sum;
    end else begin
      value = sum;
    end
  end

  assign rec_ready_o = !out_valid_q || res_o.ready;
  assign load        = rec_valid_i && rec_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Result beat valid and stored values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        gain_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (load && rec_i.sel != SEL_NONE) begin
        gain_q[rec_i.sel[1:0]] <= value;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      sel_q <= rec_i.sel;
      val_q <= value;
      ovf_q <= rec_i.overflow;
    end
  end

  // Stored values only change when a new beat loads, so they drive the port directly
  assign res_o.valid         = out_valid_q;
  assign res_o.param_select  = sel_q;
  assign res_o.parsed_value  = val_q;
  assign res_o.line_overflow = ovf_q;
  assign res_o.p_gain_value  = gain_q[0];
  assign res_o.i_gain_value  = gain_q[1];
  assign res_o.d_gain_value  = gain_q[2];
  assign res_o.target_value  = gain_q[3];

endmodule

FILE: hw/rtl/tuning_command_line_parser_core.sv
// Top level of the tuning command line parser.
//
//  channel | dir | beat                     | when
//  rx_i    | in  | one received byte        | every byte of a line
//  res_o   | out | select, value, flag, 4x | one per '!' byte
//
// One byte is taken per cycle while rx_i.ready is high. A '!' reaches res_o through
// the line tracker's record register and then the result register. Reset (rst_ni
// low, asynchronous) clears the line state and the four stored values. A stalled
// res_o holds its beat; the record register still takes one more line end before
// rx_i.ready falls.
module tuning_command_line_parser_core #(
  parameter int unsigned LINE_MAX = tclp_pkg::LineMaxDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tclp_byte_if.sink     rx_i,
  tclp_result_if.source res_o
);
  import tclp_pkg::*;

  logic      rec_valid;
  logic      rec_ready;
  line_rec_t rec;

  // Byte-by-byte line tracking
  tclp_line_tracker #(
    .LINE_MAX (LINE_MAX)
  ) u_line_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec),
    .rec_ready_i (rec_ready)
  );

  // Field value, stored values and result register
  tclp_value_unit u_value_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec),
    .rec_ready_o (rec_ready),
    .res_o       (res_o)
  );

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the tuning command line parser core.
`timescale 1ns / 1ps

module tb_top;
  import tclp_pkg::*;

  localparam int unsigned LineMax    = 200;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseBytes = 440;
  localparam int unsigned PrintCap   = 100;

  // One result beat: which value changed, the parsed value, the flag, all four stores
  typedef struct packed {
    sel_e                   sel;
    logic signed [ValW-1:0] value;
    logic                   overflow;
    logic signed [ValW-1:0] gain_p;
    logic signed [ValW-1:0] gain_i;
    logic signed [ValW-1:0] gain_d;
    logic signed [ValW-1:0] target;
  } update_t;

  // Line predictor plus the queue of updates still owed by the block
  class gain_scoreboard;
    int unsigned            line_len;
    logic [7:0]             letter;
    logic [2:0]             field_len;
    bit                     at_start;
    bit                     negative;
    bit                     overflowed;
    logic [7:0]             window [6];  // [0] is the newest field byte
    logic signed [ValW-1:0] gains [4];
    update_t                owed_q [$];
    int unsigned            mismatches;

    function new();
      foreach (gains[k]) gains[k] = '0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len   = 0;
      letter     = '0;
      field_len  = '0;
      at_start   = 1'b1;
      negative   = 1'b0;
      overflowed = 1'b0;
      foreach (window[k]) window[k] = '0;
    endfunction

    function int weight(int pos);
      return int'(window[pos]) - int'(DigitBase);
    endfunction

    // Track one accepted byte; a '!' queues the update it causes
    function void note_byte(logic [7:0] b);
      int      v;
      sel_e    s;
      update_t upd;
      v = 0;
      s = SEL_NONE;
      if (!overflowed) begin
        if (line_len >= LineMax) begin
          overflowed = 1'b1;
        end else begin
          if (line_len == 0) letter = b;
          line_len++;
        end
      end
      if (b != CharEnd) begin
        if (overflowed) return;
        if (b == CharEquals) begin
          at_start  = 1'b1;
          negative  = 1'b0;
          field_len = '0;
        end else if (at_start && b == CharMinus) begin
          at_start = 1'b0;
          negative = 1'b1;
        end else begin
          at_start = 1'b0;
          for (int k = 5; k > 0; k--) window[k] = window[k-1];
          window[0] = b;
          if (field_len < FieldLenMax) field_len++;
        end
        return;
      end
      // line end: positional decode of a 4..6 byte field
      if (!overflowed) begin
        if (field_len >= FieldLen4 && field_len <= FieldLen6) begin
          v = weight(0) + 10 * weight(1) + 100 * weight(3);
          if (field_len >= FieldLen5) v += 1000 * weight(4);
          if (field_len == FieldLen6) v += 10000 * weight(5);
        end
        if (negative) v = -v;
        case (letter)
          CharP:   s = SEL_P;
          CharI:   s = SEL_I;
          CharD:   s = SEL_D;
          CharT:   s = SEL_T;
          default: s = SEL_NONE;
        endcase
        if (s != SEL_NONE) gains[int'(s)] = v[ValW-1:0];
      end
      upd.sel      = s;
      upd.value    = v[ValW-1:0];
      upd.overflow = overflowed;
      upd.gain_p   = gains[0];
      upd.gain_i   = gains[1];
      upd.gain_d   = gains[2];
      upd.target   = gains[3];
      owed_q.push_back(upd);
      clear_line();
    endfunction

    task report(string what, int got_v, int exp_v);
      if (mismatches < PrintCap)
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got_v, exp_v);
      mismatches++;
    endtask

    // Compare one result beat with the oldest owed update
    task check_update(update_t got);
      update_t exp;
      if (owed_q.size() == 0) begin
        report("unexpected beat, select", int'(got.sel), -1);
        return;
      end
      exp = owed_q.pop_front();
      if (got.sel != exp.sel) report("param_select", int'(got.sel), int'(exp.sel));
      if (got.value != exp.value) report("parsed_value", got.value, exp.value);
      if (got.overflow != exp.overflow)
        report("line_overflow", got.overflow, exp.overflow);
      if (got.gain_p != exp.gain_p) report("p_gain_value", got.gain_p, exp.gain_p);
      if (got.gain_i != exp.gain_i) report("i_gain_value", got.gain_i, exp.gain_i);
      if (got.gain_d != exp.gain_d) report("d_gain_value", got.gain_d, exp.gain_d);
      if (got.target != exp.target) report("target_value", got.target, exp.target);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  tclp_byte_if   rx_if ();
  tclp_result_if res_if ();

  tuning_command_line_parser_core #(
    .LINE_MAX (LineMax)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  gain_scoreboard sb;
  int unsigned    idle_pct;
  int unsigned    stall_pct;
  int unsigned    bytes_sent;
  int unsigned    cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin : result_mon
    update_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.sel      = sel_e'(res_if.param_select);
      got.value    = res_if.parsed_value;
      got.overflow = res_if.line_overflow;
      got.gain_p   = res_if.p_gain_value;
      got.gain_i   = res_if.i_gain_value;
      got.gain_d   = res_if.d_gain_value;
      got.target   = res_if.target_value;
      sb.check_update(got);
    end
  end

  // Watchdog; the counter starts at zero as a two-state variable
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Offer one byte, with random gaps, until the block takes it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // Mostly a decimal digit, now and then any byte but a line end
  function automatic logic [7:0] rand_digit();
    logic [7:0] b;
    if ($urandom_range(19) == 0) begin
      b = 8'($urandom_range(255));
      if (b == CharEnd) b = CharMinus;
    end else begin
      b = 8'($urandom_range(57, 48));
    end
    return b;
  endfunction

  // One random line: well-formed in most cases, else noise or a line near or over the length limit
  task automatic send_random_line();
    logic [7:0] line_q [$];
    logic [7:0] letters [4];
    logic [7:0] b;
    int         kind;
    int         n;
    letters = '{CharP, CharI, CharD, CharT};
    kind = $urandom_range(99);
    if (kind < 3) begin
      case ($urandom_range(5))
        0:       n = LineMax - 2;
        1:       n = LineMax - 1;
        2:       n = LineMax;
        3:       n = LineMax + 1;
        4:       n = LineMax + 2;
        default: n = $urandom_range(LineMax + 100, LineMax + 3);
      endcase
      repeat (n) begin
        b = 8'($urandom_range(255));
        if (b == CharEnd) b = CharP;
        line_q.push_back(b);
      end
    end else if (kind < 20) begin
      // raw noise; a stray '!' simply ends the line early
      repeat ($urandom_range(12)) line_q.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 88) line_q.push_back(letters[$urandom_range(3)]);
      else line_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        line_q.push_back(CharEquals);
        if ($urandom_range(1)) line_q.push_back(CharMinus);
        line_q.push_back(rand_digit());
      end
      if ($urandom_range(9) != 0) line_q.push_back(CharEquals);
      if ($urandom_range(99) < 40) line_q.push_back(CharMinus);
      n = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(3, 1);
      repeat (n) line_q.push_back(rand_digit());
      line_q.push_back(8'h2E);
      n = ($urandom_range(9) == 0) ? $urandom_range(3) : 2;
      repeat (n) line_q.push_back(rand_digit());
    end
    line_q.push_back(CharEnd);
    foreach (line_q[k]) send_byte(line_q[k]);
  endtask

  // Stimulus
  initial begin
    sb            = new();
    idle_pct      = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bare terminator, largest negative target, no '=', repeated '=', extreme bytes
    send_text("!");
    send_text("T=-999.99!");
    send_text("D1.23!");
    send_text("P=-=1.05!");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CharEnd);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 88; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      while (bytes_sent < (phase + 1) * PhaseBytes) send_random_line();
    end
    rx_if.valid <= 1'b0;

    // drain the owed updates, then idle before the verdict so a stray extra beat is still checked
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
